@@ design/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg: shared types, constants and check functions
// Frame layout constants, result kinds, parser state and result records,
// and the per-byte CRC-8 / CRC-16 update functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  // Frame delimiters and check seeds
  localparam logic [7:0]  START_BYTE = 8'hA5;
  localparam logic [7:0]  CRC8_SEED  = 8'hFF;
  localparam logic [15:0] CRC16_SEED = 16'hFFFF;
  localparam logic [7:0]  CRC8_POLY  = 8'h8C;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  // Fixed byte positions inside a frame (start byte is position 0)
  localparam logic [16:0] POS_HUNT     = 17'd0;
  localparam logic [16:0] POS_LEN_LO   = 17'd1;
  localparam logic [16:0] POS_LEN_HI   = 17'd2;
  localparam logic [16:0] POS_SEQ      = 17'd3;
  localparam logic [16:0] POS_HDR_CRC  = 17'd4;
  localparam logic [16:0] POS_CMD_LO   = 17'd5;
  localparam logic [16:0] POS_CMD_HI   = 17'd6;
  localparam logic [16:0] POS_DATA     = 17'd7;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_HDR_BAD   = 2'd2,
    KIND_FRAME_BAD = 2'd3
  } cfp_kind_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [16:0] pos;
    logic [7:0]  hcrc;
    logic [15:0] fcrc;
    logic [15:0] len;
    logic [7:0]  seq;
    logic [15:0] cmd;
    logic [7:0]  tlow;
  } cfp_state_t;

  // One result record
  typedef struct packed {
    cfp_kind_t   kind;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [15:0] cmd;
    logic [7:0]  seq;
    logic [15:0] len;
  } cfp_result_t;

  localparam cfp_state_t STATE_RESET = '{
    pos:  POS_HUNT,
    hcrc: CRC8_SEED,
    fcrc: CRC16_SEED,
    len:  16'd0,
    seq:  8'd0,
    cmd:  16'd0,
    tlow: 8'd0
  };

  // Reflected CRC-8, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/cfp_rx_if.sv @@
// ----------------------------------------------------------------------------
// cfp_rx_if: received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ design/cfp_res_if.sv @@
// ----------------------------------------------------------------------------
// cfp_res_if: parser result channel
// Valid/ready channel carrying data bytes and frame status records.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] frame_cmd_id;
  logic [7:0]  frame_seq;
  logic [15:0] frame_length;

  modport source (
    output valid, output out_kind, output payload_byte, output payload_index,
    output frame_cmd_id, output frame_seq, output frame_length, input ready
  );
  modport sink (
    input valid, input out_kind, input payload_byte, input payload_index,
    input frame_cmd_id, input frame_seq, input frame_length, output ready
  );
endinterface

`default_nettype wire

@@ design/cfp_step.sv @@
// ----------------------------------------------------------------------------
// cfp_step: per-byte parser logic
// Given the current parser state and one byte, computes the next state and
// at most one result record. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_step (
  input  var cfp_pkg::cfp_state_t  state,
  input  var logic [7:0]           rx_byte,
  output var cfp_pkg::cfp_state_t  state_next,
  output var logic                 has_res,
  output var cfp_pkg::cfp_result_t res
);

  logic [16:0] data_end;
  logic [16:0] pos_inc;
  logic [16:0] data_off;
  logic [15:0] trailer;

  assign data_end = cfp_pkg::POS_DATA + {1'b0, state.len};
  assign pos_inc  = state.pos + 17'd1;
  assign data_off = state.pos - cfp_pkg::POS_DATA;
  assign trailer  = {rx_byte, state.tlow};

  always_comb begin
    state_next = state;
    has_res    = 1'b0;
    res.kind   = cfp_pkg::KIND_DATA;
    res.pbyte  = 8'd0;
    res.pidx   = 16'd0;
    res.cmd    = 16'd0;
    res.seq    = state.seq;
    res.len    = state.len;

    if (state.pos == cfp_pkg::POS_HUNT) begin
      // hunting: only a start byte opens a frame
      if (rx_byte == cfp_pkg::START_BYTE) begin
        state_next.len  = 16'd0;
        state_next.seq  = 8'd0;
        state_next.cmd  = 16'd0;
        state_next.tlow = 8'd0;
        state_next.hcrc = cfp_pkg::crc8_update(cfp_pkg::CRC8_SEED, rx_byte);
        state_next.fcrc = cfp_pkg::crc16_update(cfp_pkg::CRC16_SEED, rx_byte);
        state_next.pos  = cfp_pkg::POS_LEN_LO;
      end
    end else begin
      // frame check covers everything before the trailer
      if (state.pos < data_end) begin
        state_next.fcrc = cfp_pkg::crc16_update(state.fcrc, rx_byte);
      end

      if (state.pos <= cfp_pkg::POS_SEQ) begin
        // header bytes under the header check
        state_next.hcrc = cfp_pkg::crc8_update(state.hcrc, rx_byte);
        if (state.pos == cfp_pkg::POS_LEN_LO) begin
          state_next.len[7:0] = rx_byte;
        end else if (state.pos == cfp_pkg::POS_LEN_HI) begin
          state_next.len[15:8] = rx_byte;
        end else begin
          state_next.seq = rx_byte;
        end
        state_next.pos = pos_inc;
      end else if (state.pos == cfp_pkg::POS_HDR_CRC) begin
        // header check compare
        if (state.hcrc != rx_byte) begin
          has_res        = 1'b1;
          res.kind       = cfp_pkg::KIND_HDR_BAD;
          state_next.pos = cfp_pkg::POS_HUNT;
        end else begin
          state_next.pos = cfp_pkg::POS_CMD_LO;
        end
      end else if (state.pos == cfp_pkg::POS_CMD_LO) begin
        state_next.cmd[7:0] = rx_byte;
        state_next.pos      = cfp_pkg::POS_CMD_HI;
      end else if (state.pos == cfp_pkg::POS_CMD_HI) begin
        state_next.cmd[15:8] = rx_byte;
        state_next.pos       = cfp_pkg::POS_DATA;
      end else if (state.pos < data_end) begin
        // data byte, passed on as it arrives
        has_res        = 1'b1;
        res.kind       = cfp_pkg::KIND_DATA;
        res.pbyte      = rx_byte;
        res.pidx       = data_off[15:0];
        res.cmd        = state.cmd;
        state_next.pos = pos_inc;
      end else if (state.pos == data_end) begin
        state_next.tlow = rx_byte;
        state_next.pos  = pos_inc;
      end else begin
        // trailer high byte: frame status
        has_res        = 1'b1;
        res.kind       = (trailer == state.fcrc) ? cfp_pkg::KIND_GOOD
                                                 : cfp_pkg::KIND_FRAME_BAD;
        res.cmd        = state.cmd;
        state_next.pos = cfp_pkg::POS_HUNT;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/crc_checked_serial_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// crc_checked_serial_frame_parser_unit: framed serial deframer
// Hunts for start bytes, checks the header CRC-8 and the frame CRC-16,
// passes data bytes on as they arrive and ends each frame with a status.
// ----------------------------------------------------------------------------
// Path: a byte transfer reaches its result through the input register, then
//   the parser logic into the result register, from which the result transfers.
// Throughput: one byte per cycle, stalled while a pending result is not taken.
// Reset (synchronous, active high): empties both registers and returns the
//   parser to hunting with both checks seeded.
`default_nettype none

module crc_checked_serial_frame_parser_unit (
  input  var logic   clk,
  input  var logic   rst,
  cfp_rx_if.sink     rx,
  cfp_res_if.source  res
);

  // input register
  logic       stg_valid;
  logic [7:0] stg_byte;

  // parser state and result register
  cfp_pkg::cfp_state_t  state;
  cfp_pkg::cfp_state_t  state_next;
  cfp_pkg::cfp_result_t step_res;
  cfp_pkg::cfp_result_t res_q;
  logic                 step_has_res;
  logic                 res_valid;
  logic                 advance;
  logic                 load_res;

  assign advance  = stg_valid && (!res_valid || res.ready);
  assign load_res = advance && step_has_res;
  assign rx.ready = !stg_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (rx.ready) begin
      stg_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stg_byte <= rx.rx_byte;
    end
  end

  cfp_step u_step (
    .state      (state),
    .rx_byte    (stg_byte),
    .state_next (state_next),
    .has_res    (step_has_res),
    .res        (step_res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_q <= step_res;
    end
  end

  assign res.valid         = res_valid;
  assign res.out_kind      = res_q.kind;
  assign res.payload_byte  = res_q.pbyte;
  assign res.payload_index = res_q.pidx;
  assign res.frame_cmd_id  = res_q.cmd;
  assign res.frame_seq     = res_q.seq;
  assign res.frame_length  = res_q.len;

  // checks
  a_load_needs_byte: assert property (@(posedge clk) disable iff (rst)
    load_res |-> stg_valid)
    else $error("result loaded without a staged byte");

  a_hunt_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && state.pos == cfp_pkg::POS_HUNT) |-> !step_has_res)
    else $error("result produced while hunting");

  a_hdr_fail_hunts: assert property (@(posedge clk) disable iff (rst)
    (load_res && step_res.kind == cfp_pkg::KIND_HDR_BAD) |=>
      (state.pos == cfp_pkg::POS_HUNT))
    else $error("header failure did not return to hunting");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state.pos <= ({1'b0, state.len} + 17'd8))
    else $error("byte position past frame trailer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !load_res)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
